>>> rtl/core/double_polynomial_substring_hash_assert.svh
// Assertion macros shared by the substring hash RTL.
// Included by the modules that carry concurrent assertions; needs no package.
`ifndef DOUBLE_POLYNOMIAL_SUBSTRING_HASH_ASSERT_SVH
`define DOUBLE_POLYNOMIAL_SUBSTRING_HASH_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DPH_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DPH_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/dph_pkg.sv
// Package for the double-modulus polynomial substring hash.
// Holds widths, moduli, codes, shared structs and the small modular step.
// No dependencies.
package dph_pkg;

  localparam int unsigned MaxLen     = 1024;
  localparam int unsigned AddrW      = $clog2(MaxLen + 1);
  localparam int unsigned HashW      = 30;
  localparam int unsigned KindW      = 2;
  localparam int unsigned LetterW    = 8;
  localparam int unsigned PosW       = 11;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned LetterValW = 5;
  localparam int unsigned BaseW      = 6;

  localparam logic [HashW-1:0]   ModOne  = 30'd1000000007;
  localparam logic [HashW-1:0]   ModTwo  = 30'd1000000009;
  localparam logic [BaseW-1:0]   BaseOne = 6'd31;
  localparam logic [BaseW-1:0]   BaseTwo = 6'd37;
  localparam logic [LetterW-1:0] LetterA = 8'd97;
  localparam logic [LetterW-1:0] LetterZ = 8'd122;

  // Barrett constants: floor(2^(2*HashW) / modulus).
  localparam logic [HashW:0] MuOne = (HashW + 1)'((64'd1 << (2 * HashW)) / 64'(ModOne));
  localparam logic [HashW:0] MuTwo = (HashW + 1)'((64'd1 << (2 * HashW)) / 64'(ModTwo));

  typedef enum logic [KindW-1:0] {
    KIND_APPEND  = 2'd0,
    KIND_QUERY   = 2'd1,
    KIND_RESTART = 2'd2
  } dph_kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK         = 2'd0,
    ST_BAD_LETTER = 2'd1,
    ST_FULL       = 2'd2,
    ST_RANGE      = 2'd3
  } dph_status_e;

  // One input beat as held in the input register.
  typedef struct packed {
    logic               valid;
    logic [KindW-1:0]   kind;
    logic [LetterW-1:0] letter;
    logic [PosW-1:0]    left_pos;
    logic [PosW-1:0]    right_pos;
  } dph_item_t;

  // Operands handed from the prefix store to the span pipeline.
  typedef struct packed {
    logic             valid;
    dph_status_e      status;
    logic             use_sub;
    logic [HashW-1:0] base_one;
    logic [HashW-1:0] base_two;
    logic [HashW-1:0] lo_one;
    logic [HashW-1:0] lo_two;
    logic [HashW-1:0] pow_one;
    logic [HashW-1:0] pow_two;
  } dph_span_req_t;

  // Finished result leaving the span pipeline.
  typedef struct packed {
    logic             valid;
    dph_status_e      status;
    logic [HashW-1:0] hash_one;
    logic [HashW-1:0] hash_two;
  } dph_result_t;

  // Computes (a * b + v) mod m for a < m, a small base b and a letter value v.
  // The bits above 2^30 are folded back with 2^30 mod m, which leaves a value
  // below 4m; one selected subtraction finishes the reduction.
  function automatic logic [HashW-1:0] dph_mul_add_mod(
    input logic [HashW-1:0]      a,
    input logic [BaseW-1:0]      b,
    input logic [LetterValW-1:0] v,
    input logic [HashW-1:0]      m
  );
    logic [HashW+BaseW-1:0] x;
    logic [HashW-1:0]       c;
    logic [31:0]            m32;
    logic [31:0]            fold;
    logic [31:0]            r;
    x    = (HashW + BaseW)'(a) * (HashW + BaseW)'(b) + (HashW + BaseW)'(v);
    c    = '0 - m;
    m32  = 32'(m);
    fold = 32'(x[HashW+BaseW-1:HashW]) * 32'(c) + 32'(x[HashW-1:0]);
    if (fold >= m32 * 32'd3) begin
      r = fold - m32 * 32'd3;
    end else if (fold >= m32 * 32'd2) begin
      r = fold - m32 * 32'd2;
    end else if (fold >= m32) begin
      r = fold - m32;
    end else begin
      r = fold;
    end
    return r[HashW-1:0];
  endfunction

endpackage

>>> rtl/core/dph_if.sv
// Handshake interfaces for the input beats and the result beats.
// Depends on dph_pkg for the field widths.
interface dph_item_if import dph_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KindW-1:0]   kind;
  logic [LetterW-1:0] letter;
  logic [PosW-1:0]    left_pos;
  logic [PosW-1:0]    right_pos;

  modport source (output valid, kind, letter, left_pos, right_pos, input ready);
  modport sink   (input valid, kind, letter, left_pos, right_pos, output ready);
endinterface

interface dph_result_if import dph_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [HashW-1:0]   hash_one;
  logic [HashW-1:0]   hash_two;
  logic [StatusW-1:0] status;

  modport source (output valid, hash_one, hash_two, status, input ready);
  modport sink   (input valid, hash_one, hash_two, status, output ready);
endinterface

>>> rtl/core/dph_store.sv
// Prefix store: letter count, tail hashes, the four prefix memories and span checks.
// Depends on dph_pkg and the assertion macro header.
`include "double_polynomial_substring_hash_assert.svh"

module dph_store import dph_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  dph_item_t     item_i,
  output dph_span_req_t req_o
);

  logic [AddrW-1:0]      count_q, count_d;
  logic [HashW-1:0]      tail_one_q, tail_one_d, tail_two_q, tail_two_d;
  logic [HashW-1:0]      tpow_one_q, tpow_one_d, tpow_two_q, tpow_two_d;
  logic [HashW-1:0]      next_hash_one, next_hash_two, next_pow_one, next_pow_two;
  logic [LetterValW-1:0] letter_val;
  logic [AddrW-1:0]      wr_addr, rd_lo, rd_hi, rd_d;
  logic [PosW-1:0]       left_m1;
  logic                  is_append, is_query, is_restart;
  logic                  letter_ok, full, append_ok, query_ok, wr_en;
  logic                  has_result;
  dph_status_e           status_d;

  // Prefix memories; entry zero is never written and is replaced on read.
  logic [HashW-1:0] hash_one_mem [MaxLen+1];
  logic [HashW-1:0] hash_two_mem [MaxLen+1];
  logic [HashW-1:0] pow_one_mem  [MaxLen+1];
  logic [HashW-1:0] pow_two_mem  [MaxLen+1];

  // Read data and side band of the first pipeline stage.
  logic [HashW-1:0] rd_lo_one_q, rd_hi_one_q, rd_lo_two_q, rd_hi_two_q;
  logic [HashW-1:0] rd_pow_one_q, rd_pow_two_q;
  logic [HashW-1:0] app_one_q, app_two_q;
  logic             z_lo_q, z_hi_q, z_d_q;
  logic             s1_valid_q, s1_use_sub_q;
  dph_status_e      s1_status_q;

  // Decode the beat in the input register.
  assign is_append  = item_i.valid && (item_i.kind == KIND_APPEND);
  assign is_query   = item_i.valid && (item_i.kind == KIND_QUERY);
  assign is_restart = item_i.valid && (item_i.kind == KIND_RESTART);
  assign has_result = is_append || is_query;

  // Append checks and the next prefix values from the tail registers.
  assign letter_ok  = (item_i.letter >= LetterA) && (item_i.letter <= LetterZ);
  assign full       = count_q >= AddrW'(MaxLen);
  assign append_ok  = is_append && letter_ok && !full;
  assign wr_en      = en_i && append_ok;
  assign wr_addr    = count_q + 1'b1;
  assign letter_val = LetterValW'(item_i.letter - LetterA + 8'd1);

  assign next_hash_one = dph_mul_add_mod(tail_one_q, BaseOne, letter_val, ModOne);
  assign next_hash_two = dph_mul_add_mod(tail_two_q, BaseTwo, letter_val, ModTwo);
  assign next_pow_one  = dph_mul_add_mod(tpow_one_q, BaseOne, '0, ModOne);
  assign next_pow_two  = dph_mul_add_mod(tpow_two_q, BaseTwo, '0, ModTwo);

  // Span check and read addresses; a rejected span reads entry zero.
  assign left_m1  = item_i.left_pos - 1'b1;
  assign query_ok = is_query && (item_i.left_pos != '0)
                 && ((PosW + 1)'(item_i.right_pos) <= (PosW + 1)'(count_q))
                 && ((PosW + 1)'(item_i.left_pos) <= (PosW + 1)'(item_i.right_pos) + 1'b1);
  assign rd_lo = query_ok ? AddrW'(left_m1) : '0;
  assign rd_hi = query_ok ? AddrW'(item_i.right_pos) : '0;
  assign rd_d  = rd_hi - rd_lo;

  // Status of the beat.
  always_comb begin
    status_d = ST_OK;
    case (item_i.kind)
      KIND_APPEND: begin
        if (!letter_ok) begin
          status_d = ST_BAD_LETTER;
        end else if (full) begin
          status_d = ST_FULL;
        end
      end
      KIND_QUERY: begin
        if (!query_ok) begin
          status_d = ST_RANGE;
        end
      end
      default: status_d = ST_OK;
    endcase
  end

  // Count and tail update: a good append extends, a restart empties.
  always_comb begin
    count_d    = count_q;
    tail_one_d = tail_one_q;
    tail_two_d = tail_two_q;
    tpow_one_d = tpow_one_q;
    tpow_two_d = tpow_two_q;
    if (en_i && append_ok) begin
      count_d    = wr_addr;
      tail_one_d = next_hash_one;
      tail_two_d = next_hash_two;
      tpow_one_d = next_pow_one;
      tpow_two_d = next_pow_two;
    end else if (en_i && is_restart) begin
      count_d    = '0;
      tail_one_d = '0;
      tail_two_d = '0;
      tpow_one_d = HashW'(1);
      tpow_two_d = HashW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      tail_one_q <= '0;
      tail_two_q <= '0;
      tpow_one_q <= HashW'(1);
      tpow_two_q <= HashW'(1);
    end else begin
      count_q    <= count_d;
      tail_one_q <= tail_one_d;
      tail_two_q <= tail_two_d;
      tpow_one_q <= tpow_one_d;
      tpow_two_q <= tpow_two_d;
    end
  end

  // Stage one control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      s1_use_sub_q <= 1'b0;
      s1_status_q  <= ST_OK;
    end else if (en_i) begin
      s1_valid_q   <= has_result;
      s1_use_sub_q <= query_ok;
      s1_status_q  <= status_d;
    end
  end

  // Stage one payload: appended hashes and entry-zero flags.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      app_one_q <= append_ok ? next_hash_one : '0;
      app_two_q <= append_ok ? next_hash_two : '0;
      z_lo_q    <= rd_lo == '0;
      z_hi_q    <= rd_hi == '0;
      z_d_q     <= rd_d == '0;
    end
  end

  // Prefix hash memories: one write, two registered reads.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hash_one_mem[wr_addr] <= next_hash_one;
      hash_two_mem[wr_addr] <= next_hash_two;
    end
    if (en_i) begin
      rd_lo_one_q <= hash_one_mem[rd_lo];
      rd_hi_one_q <= hash_one_mem[rd_hi];
      rd_lo_two_q <= hash_two_mem[rd_lo];
      rd_hi_two_q <= hash_two_mem[rd_hi];
    end
  end

  // Power memories: one write, one registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pow_one_mem[wr_addr] <= next_pow_one;
      pow_two_mem[wr_addr] <= next_pow_two;
    end
    if (en_i) begin
      rd_pow_one_q <= pow_one_mem[rd_d];
      rd_pow_two_q <= pow_two_mem[rd_d];
    end
  end

  // Entry zero reads as hash zero and power one.
  always_comb begin
    req_o.valid    = s1_valid_q;
    req_o.status   = s1_status_q;
    req_o.use_sub  = s1_use_sub_q;
    req_o.base_one = s1_use_sub_q ? (z_hi_q ? '0 : rd_hi_one_q) : app_one_q;
    req_o.base_two = s1_use_sub_q ? (z_hi_q ? '0 : rd_hi_two_q) : app_two_q;
    req_o.lo_one   = z_lo_q ? '0 : rd_lo_one_q;
    req_o.lo_two   = z_lo_q ? '0 : rd_lo_two_q;
    req_o.pow_one  = z_d_q ? HashW'(1) : rd_pow_one_q;
    req_o.pow_two  = z_d_q ? HashW'(1) : rd_pow_two_q;
  end

  `DPH_ASSERT_IMPLY(a_count_max, clk_i, rst_ni, 1'b1, count_q <= AddrW'(MaxLen),
                    "letter count beyond store depth")
  `DPH_ASSERT_NEXT(a_count_step, clk_i, rst_ni, wr_en,
                   count_q == AddrW'($past(count_q) + 1'b1),
                   "good append did not advance the letter count")
  `DPH_ASSERT_IMPLY(a_tail_reduced, clk_i, rst_ni, 1'b1,
                    (tail_one_q < ModOne) && (tail_two_q < ModTwo)
                    && (tpow_one_q < ModOne) && (tpow_two_q < ModTwo),
                    "tail value not reduced below its modulus")

endmodule

>>> rtl/core/dph_span_pipe.sv
// Span pipeline: h[lo] * P[len] with Barrett reduction, then h[hi] minus that product.
// Depends on dph_pkg.
module dph_span_pipe import dph_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  dph_span_req_t req_i,
  output dph_result_t   res_o
);

  localparam int unsigned ProdW = 2 * HashW;
  localparam int unsigned QW    = HashW + 1;
  localparam int unsigned RemW  = HashW + 2;

  typedef struct packed {
    logic             valid;
    dph_status_e      status;
    logic             use_sub;
    logic [HashW-1:0] base_one;
    logic [HashW-1:0] base_two;
  } dph_meta_t;

  dph_meta_t        meta_s2_q, meta_s3_q, meta_s4_q, meta_s5_q;
  logic [ProdW-1:0] prod_one_s2_q, prod_two_s2_q;
  logic [2*QW-1:0]  bq_one, bq_two;
  logic [QW-1:0]    q_one_s3_q, q_two_s3_q;
  logic [RemW-1:0]  low_one_s3_q, low_two_s3_q;
  logic [RemW-1:0]  r0_one_s4_q, r0_two_s4_q;
  logic [RemW-1:0]  mod_one_r, mod_two_r;
  logic [HashW-1:0] sub_one_d, sub_two_d, sub_one_s5_q, sub_two_s5_q;
  logic [HashW-1:0] diff_one, diff_two;

  assign mod_one_r = RemW'(ModOne);
  assign mod_two_r = RemW'(ModTwo);

  // Side band follows the operands through every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_s2_q <= '0;
      meta_s3_q <= '0;
      meta_s4_q <= '0;
      meta_s5_q <= '0;
    end else if (en_i) begin
      meta_s2_q <= '{valid: req_i.valid, status: req_i.status, use_sub: req_i.use_sub,
                     base_one: req_i.base_one, base_two: req_i.base_two};
      meta_s3_q <= meta_s2_q;
      meta_s4_q <= meta_s3_q;
      meta_s5_q <= meta_s4_q;
    end
  end

  // Quotient estimate from the top bits of the product.
  assign bq_one = (2 * QW)'(QW'(prod_one_s2_q >> (HashW - 1))) * (2 * QW)'(MuOne);
  assign bq_two = (2 * QW)'(QW'(prod_two_s2_q >> (HashW - 1))) * (2 * QW)'(MuTwo);

  // Remainder estimate is below three moduli; pick the one correction needed.
  always_comb begin
    if (r0_one_s4_q >= (mod_one_r << 1)) begin
      sub_one_d = HashW'(r0_one_s4_q - (mod_one_r << 1));
    end else if (r0_one_s4_q >= mod_one_r) begin
      sub_one_d = HashW'(r0_one_s4_q - mod_one_r);
    end else begin
      sub_one_d = HashW'(r0_one_s4_q);
    end
    if (r0_two_s4_q >= (mod_two_r << 1)) begin
      sub_two_d = HashW'(r0_two_s4_q - (mod_two_r << 1));
    end else if (r0_two_s4_q >= mod_two_r) begin
      sub_two_d = HashW'(r0_two_s4_q - mod_two_r);
    end else begin
      sub_two_d = HashW'(r0_two_s4_q);
    end
  end

  // Datapath registers: product, quotient, raw remainder, reduced remainder.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_one_s2_q <= ProdW'(req_i.lo_one) * ProdW'(req_i.pow_one);
      prod_two_s2_q <= ProdW'(req_i.lo_two) * ProdW'(req_i.pow_two);
      q_one_s3_q    <= QW'(bq_one >> (HashW + 1));
      q_two_s3_q    <= QW'(bq_two >> (HashW + 1));
      low_one_s3_q  <= prod_one_s2_q[RemW-1:0];
      low_two_s3_q  <= prod_two_s2_q[RemW-1:0];
      r0_one_s4_q   <= low_one_s3_q - RemW'(q_one_s3_q) * mod_one_r;
      r0_two_s4_q   <= low_two_s3_q - RemW'(q_two_s3_q) * mod_two_r;
      sub_one_s5_q  <= sub_one_d;
      sub_two_s5_q  <= sub_two_d;
    end
  end

  // Modular difference h[hi] - sub; both operands are already reduced.
  assign diff_one = (meta_s5_q.base_one >= sub_one_s5_q)
                  ? meta_s5_q.base_one - sub_one_s5_q
                  : meta_s5_q.base_one + (ModOne - sub_one_s5_q);
  assign diff_two = (meta_s5_q.base_two >= sub_two_s5_q)
                  ? meta_s5_q.base_two - sub_two_s5_q
                  : meta_s5_q.base_two + (ModTwo - sub_two_s5_q);

  always_comb begin
    res_o.valid    = meta_s5_q.valid;
    res_o.status   = meta_s5_q.status;
    res_o.hash_one = meta_s5_q.use_sub ? diff_one : meta_s5_q.base_one;
    res_o.hash_two = meta_s5_q.use_sub ? diff_two : meta_s5_q.base_two;
  end

endmodule

>>> rtl/core/double_polynomial_substring_hash.sv
// A result beat passes the input register, the store and span stages and the
// output register. Throughput: one beat per cycle while not stalled; an append
// updates the tail registers directly, so appends and queries stream back to back.
// The whole pipeline stalls only while the output register holds an untaken beat.
// Reset empties the string at once; no memory clearing pass is needed.
// Depends on dph_pkg, dph_if, dph_store, dph_span_pipe and the assertion header.
`include "double_polynomial_substring_hash_assert.svh"

module double_polynomial_substring_hash import dph_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  dph_item_if.sink     item_i,
  dph_result_if.source result_o
);

  logic             advance;
  dph_item_t        s0_q;
  dph_span_req_t    span_req;
  dph_result_t      span_res;
  logic             out_valid_q;
  logic [HashW-1:0] out_hash_one_q, out_hash_two_q;
  dph_status_e      out_status_q;

  // The pipeline moves whenever the output register can take a beat.
  assign advance     = !out_valid_q || result_o.ready;
  assign item_i.ready = advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q <= '0;
    end else if (advance) begin
      s0_q <= '{valid: item_i.valid, kind: item_i.kind, letter: item_i.letter,
                left_pos: item_i.left_pos, right_pos: item_i.right_pos};
    end
  end

  dph_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (s0_q),
    .req_o  (span_req)
  );

  dph_span_pipe u_span_pipe (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .req_i  (span_req),
    .res_o  (span_res)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= span_res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_hash_one_q <= span_res.hash_one;
      out_hash_two_q <= span_res.hash_two;
      out_status_q   <= span_res.status;
    end
  end

  assign result_o.valid    = out_valid_q;
  assign result_o.hash_one = out_hash_one_q;
  assign result_o.hash_two = out_hash_two_q;
  assign result_o.status   = out_status_q;

  `DPH_ASSERT_IMPLY(a_out_reduced, clk_i, rst_ni, out_valid_q,
                    (out_hash_one_q < ModOne) && (out_hash_two_q < ModTwo),
                    "result hash not below its modulus")
  `DPH_ASSERT_IMPLY(a_err_zero, clk_i, rst_ni, out_valid_q && (out_status_q != ST_OK),
                    (out_hash_one_q == '0) && (out_hash_two_q == '0),
                    "error beat carries nonzero hashes")
  `DPH_ASSERT_IMPLY(a_stall_blocks_input, clk_i, rst_ni, out_valid_q && !result_o.ready,
                    !item_i.ready, "input taken while the output beat is stalled")

endmodule
